// File: design/rbsi_pkg.sv
// Shared constants, face codes and saturation helper for the ray/box slab unit.
package rbsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_LEVEL_DEF = 14;
    localparam int DIV_STAGES    = 32;

    localparam logic [2:0] FACE_X_LO = 3'd0;
    localparam logic [2:0] FACE_X_HI = 3'd1;
    localparam logic [2:0] FACE_Y_LO = 3'd2;
    localparam logic [2:0] FACE_Y_HI = 3'd3;
    localparam logic [2:0] FACE_Z_LO = 3'd4;
    localparam logic [2:0] FACE_Z_HI = 3'd5;

    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;

    // signed result from sign and magnitude, clipped to 32 bits
    function automatic logic signed [31:0] sat32(input logic neg, input logic [32:0] mag);
        logic signed [31:0] r;
        if (neg) begin
            if (mag[32] || mag[31]) begin
                r = T_MIN;
            end else begin
                r = -$signed({1'b0, mag[30:0]});
            end
        end else begin
            if (mag[32] || mag[31]) begin
                r = T_MAX;
            end else begin
                r = $signed({1'b0, mag[30:0]});
            end
        end
        return r;
    endfunction

endpackage

// File: design/rbsi_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturation flag on overflow.
module rbsi_div #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF,
    parameter int NUMW      = 34
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NUMW-1:0]   num_mag,
    input  logic [32:0]       den,
    output logic [31:0]       quo,
    output logic              sat
);

    localparam int STAGES = rbsi_pkg::DIV_STAGES;
    localparam int NMW    = NUMW + FRAC_BITS;
    localparam int HW     = NMW - 32;
    localparam int CW     = ((HW > 33) ? HW : 33) + 1;

    logic [NMW-1:0] nsh;
    logic [CW-1:0]  nhi_w;
    logic [CW-1:0]  den_w;
    logic           sat_in;

    logic [32:0] rem_reg [0:STAGES-1];
    logic [31:0] wrd_reg [0:STAGES-1];
    logic [32:0] den_reg [0:STAGES-1];
    logic        sat_reg [0:STAGES-1];

    always_comb begin
        nsh    = NMW'(num_mag) << FRAC_BITS;
        nhi_w  = CW'(nsh[NMW-1:32]);
        den_w  = CW'(den);
        sat_in = (nhi_w >= den_w);
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [32:0] src_rem;
        logic [31:0] src_wrd;
        logic [32:0] src_den;
        logic        src_sat;
        logic [33:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign src_rem = nhi_w[32:0];
            assign src_wrd = nsh[31:0];
            assign src_den = den;
            assign src_sat = sat_in;
        end else begin : g_rest
            assign src_rem = rem_reg[k-1];
            assign src_wrd = wrd_reg[k-1];
            assign src_den = den_reg[k-1];
            assign src_sat = sat_reg[k-1];
        end

        assign trial = {src_rem, src_wrd[31]};
        assign ge    = (trial >= {1'b0, src_den});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? 33'(trial - {1'b0, src_den}) : trial[32:0];
                wrd_reg[k] <= {src_wrd[30:0], ge};
                den_reg[k] <= src_den;
                sat_reg[k] <= src_sat;
            end
        end
    end

    assign quo = wrd_reg[STAGES-1];
    assign sat = sat_reg[STAGES-1];

endmodule

// File: design/ray_box_slab_intersect_unit.sv
// Top level of the ray segment against axis-aligned cube slab test.
//
// Usage:
//   Input channel s_*: ray start and end (Q16.16) plus the cube corner and
//   level. One transfer per cycle is accepted while s_ready is high.
//   Result channel m_*: hit flag, entry t, entered face and hit point; all
//   fields read zero when there is no hit.
//   m_valid rises after the input transfer once the item has passed the input
//   register, loaded at the transfer edge, then 32 stages of the six restoring dividers
//   (one quotient bit per stage, which sets the depth), then four stages for
//   selection and the hit-point multiply, and the output register.
//   Throughput is one item per cycle while the receiver does not stall.
//   The whole pipeline advances when the output register is empty or being
//   taken; a receiver stall freezes every stage in place, so nothing is lost
//   or duplicated, and s_ready falls until the stall clears.
//   Reset (aresetn low, synchronous) clears all valid bits; the unit is
//   ready once reset is released.
module ray_box_slab_intersect_unit #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF,
    parameter int MAX_LEVEL = rbsi_pkg::MAX_LEVEL_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_start_x,
    input  logic signed [31:0] s_start_y,
    input  logic signed [31:0] s_start_z,
    input  logic signed [31:0] s_end_x,
    input  logic signed [31:0] s_end_y,
    input  logic signed [31:0] s_end_z,
    input  logic signed [15:0] s_box_x,
    input  logic signed [15:0] s_box_y,
    input  logic signed [15:0] s_box_z,
    input  logic        [3:0]  s_box_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic signed [31:0] m_t_entry,
    output logic        [2:0]  m_face,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic signed [31:0] m_point_z
);

    localparam int STAGES = rbsi_pkg::DIV_STAGES;
    localparam int PW     = 17 + FRAC_BITS;
    localparam int NUMW   = ((PW > 32) ? PW : 32) + 1;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [32:0] d;
        logic               neg_lo;
        logic               neg_hi;
        logic               zero;
        logic               in_slab;
    } side_t;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // input stage
    logic signed [31:0]     s_in   [3];
    logic signed [31:0]     e_in   [3];
    logic signed [15:0]     b_in   [3];
    logic [3:0]             lvl;
    logic signed [PW-1:0]   lo_c   [3];
    logic signed [PW-1:0]   hi_c   [3];

    logic                   v1_reg;
    logic signed [31:0]     s1_reg   [3];
    logic signed [32:0]     d1_reg   [3];
    logic signed [NUMW-1:0] nlo1_reg [3];
    logic signed [NUMW-1:0] nhi1_reg [3];

    always_comb begin
        s_in[0] = s_start_x; s_in[1] = s_start_y; s_in[2] = s_start_z;
        e_in[0] = s_end_x;   e_in[1] = s_end_y;   e_in[2] = s_end_z;
        b_in[0] = s_box_x;   b_in[1] = s_box_y;   b_in[2] = s_box_z;
        lvl = (s_box_level > 4'(MAX_LEVEL)) ? 4'(MAX_LEVEL) : s_box_level;
        for (int a = 0; a < 3; a++) begin
            lo_c[a] = PW'(b_in[a]) <<< FRAC_BITS;
            hi_c[a] = (PW'(b_in[a]) + (PW'(1) << lvl)) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                s1_reg[a]   <= s_in[a];
                d1_reg[a]   <= 33'(e_in[a]) - 33'(s_in[a]);
                nlo1_reg[a] <= NUMW'(lo_c[a]) - NUMW'(s_in[a]);
                nhi1_reg[a] <= NUMW'(hi_c[a]) - NUMW'(s_in[a]);
            end
        end
    end

    // divider feed
    logic [NUMW-1:0] mlo  [3];
    logic [NUMW-1:0] mhi  [3];
    logic [32:0]     ud   [3];
    logic [31:0]     qlo  [3];
    logic [31:0]     qhi  [3];
    logic            slo  [3];
    logic            shi  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mlo[a] = nlo1_reg[a][NUMW-1] ? NUMW'(-nlo1_reg[a]) : NUMW'(nlo1_reg[a]);
            mhi[a] = nhi1_reg[a][NUMW-1] ? NUMW'(-nhi1_reg[a]) : NUMW'(nhi1_reg[a]);
            ud[a]  = d1_reg[a][32] ? 33'(-d1_reg[a]) : 33'(d1_reg[a]);
        end
    end

    side_t side_in [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            side_in[a].s       = s1_reg[a];
            side_in[a].d       = d1_reg[a];
            side_in[a].neg_lo  = (nlo1_reg[a][NUMW-1] != d1_reg[a][32]) && (nlo1_reg[a] != '0);
            side_in[a].neg_hi  = (nhi1_reg[a][NUMW-1] != d1_reg[a][32]) && (nhi1_reg[a] != '0);
            side_in[a].zero    = (d1_reg[a] == '0);
            side_in[a].in_slab = (nlo1_reg[a] <= 0) && (nhi1_reg[a] >= 0);
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_div #(.FRAC_BITS(FRAC_BITS), .NUMW(NUMW)) u_div_lo (
            .aclk(aclk), .en(en), .num_mag(mlo[a]), .den(ud[a]),
            .quo(qlo[a]), .sat(slo[a])
        );
        rbsi_div #(.FRAC_BITS(FRAC_BITS), .NUMW(NUMW)) u_div_hi (
            .aclk(aclk), .en(en), .num_mag(mhi[a]), .den(ud[a]),
            .quo(qhi[a]), .sat(shi[a])
        );
    end

    // side line alongside the dividers
    logic  vd_reg   [0:STAGES-1];
    side_t sd_reg   [0:STAGES-1][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STAGES; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vd_reg[0] <= v1_reg;
            for (int k = 1; k < STAGES; k++) begin
                vd_reg[k] <= vd_reg[k-1];
            end
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                sd_reg[0][a] <= side_in[a];
                for (int k = 1; k < STAGES; k++) begin
                    sd_reg[k][a] <= sd_reg[k-1][a];
                end
            end
        end
    end

    // P2: saturated plane t values
    logic               v2_reg;
    logic               miss2_reg;
    logic signed [31:0] tlo2_reg [3];
    logic signed [31:0] thi2_reg [3];
    logic signed [31:0] s2_reg   [3];
    logic signed [32:0] d2_reg   [3];
    logic signed [31:0] tlo_c    [3];
    logic signed [31:0] thi_c    [3];
    logic               miss_c;

    always_comb begin
        miss_c = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (sd_reg[STAGES-1][a].zero) begin
                tlo_c[a] = rbsi_pkg::T_MIN;
                thi_c[a] = rbsi_pkg::T_MAX;
                miss_c   = miss_c || !sd_reg[STAGES-1][a].in_slab;
            end else begin
                tlo_c[a] = rbsi_pkg::sat32(sd_reg[STAGES-1][a].neg_lo,
                                           slo[a] ? 33'h1_0000_0000 : {1'b0, qlo[a]});
                thi_c[a] = rbsi_pkg::sat32(sd_reg[STAGES-1][a].neg_hi,
                                           shi[a] ? 33'h1_0000_0000 : {1'b0, qhi[a]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= vd_reg[STAGES-1];
        end
        if (en) begin
            miss2_reg <= miss_c;
            for (int a = 0; a < 3; a++) begin
                tlo2_reg[a] <= tlo_c[a];
                thi2_reg[a] <= thi_c[a];
                s2_reg[a]   <= sd_reg[STAGES-1][a].s;
                d2_reg[a]   <= sd_reg[STAGES-1][a].d;
            end
        end
    end

    // P3: per-axis entry and exit
    logic               v3_reg;
    logic               miss3_reg;
    logic signed [31:0] tin3_reg  [3];
    logic signed [31:0] tout3_reg [3];
    logic signed [31:0] tlo3_reg  [3];
    logic signed [31:0] s3_reg    [3];
    logic signed [32:0] d3_reg    [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            miss3_reg <= miss2_reg;
            for (int a = 0; a < 3; a++) begin
                if (tlo2_reg[a] < thi2_reg[a]) begin
                    tin3_reg[a]  <= tlo2_reg[a];
                    tout3_reg[a] <= thi2_reg[a];
                end else begin
                    tin3_reg[a]  <= thi2_reg[a];
                    tout3_reg[a] <= tlo2_reg[a];
                end
                tlo3_reg[a] <= tlo2_reg[a];
                s3_reg[a]   <= s2_reg[a];
                d3_reg[a]   <= d2_reg[a];
            end
        end
    end

    // P4: greatest entry, least exit, face
    logic signed [31:0] tmax_c;
    logic signed [31:0] tmin_c;
    logic [2:0]         face_c;
    logic               hit_c;

    always_comb begin
        tmax_c = tin3_reg[0];
        tmin_c = tout3_reg[0];
        for (int a = 1; a < 3; a++) begin
            if (tin3_reg[a] > tmax_c) begin
                tmax_c = tin3_reg[a];
            end
            if (tout3_reg[a] < tmin_c) begin
                tmin_c = tout3_reg[a];
            end
        end
        hit_c = !miss3_reg && (tmax_c < tmin_c);
        if (tin3_reg[0] == tmax_c) begin
            face_c = (tlo3_reg[0] == tmax_c) ? rbsi_pkg::FACE_X_LO : rbsi_pkg::FACE_X_HI;
        end else if (tin3_reg[1] == tmax_c) begin
            face_c = (tlo3_reg[1] == tmax_c) ? rbsi_pkg::FACE_Y_LO : rbsi_pkg::FACE_Y_HI;
        end else begin
            face_c = (tlo3_reg[2] == tmax_c) ? rbsi_pkg::FACE_Z_LO : rbsi_pkg::FACE_Z_HI;
        end
    end

    logic               v4_reg;
    logic               hit4_reg;
    logic [2:0]         face4_reg;
    logic signed [31:0] t4_reg   [3];
    logic signed [31:0] s4_reg   [3];
    logic signed [32:0] d4_reg   [3];
    logic signed [31:0] tm4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            hit4_reg  <= hit_c;
            face4_reg <= face_c;
            tm4_reg   <= tmax_c;
            for (int a = 0; a < 3; a++) begin
                t4_reg[a] <= tmax_c;
                s4_reg[a] <= s3_reg[a];
                d4_reg[a] <= d3_reg[a];
            end
        end
    end

    // P5: |t| * |delta|
    logic               v5_reg;
    logic               hit5_reg;
    logic [2:0]         face5_reg;
    logic signed [31:0] tm5_reg;
    logic [64:0]        prod5_reg [3];
    logic               neg5_reg  [3];
    logic signed [31:0] s5_reg    [3];
    logic [32:0]        ut        [3];
    logic [32:0]        udd       [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ut[a]  = t4_reg[a][31] ? 33'(-33'(t4_reg[a])) : 33'(t4_reg[a]);
            udd[a] = d4_reg[a][32] ? 33'(-d4_reg[a]) : 33'(d4_reg[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            hit5_reg  <= hit4_reg;
            face5_reg <= face4_reg;
            tm5_reg   <= tm4_reg;
            for (int a = 0; a < 3; a++) begin
                prod5_reg[a] <= 65'(ut[a]) * 65'(udd[a]);
                neg5_reg[a]  <= t4_reg[a][31] != d4_reg[a][32];
                s5_reg[a]    <= s4_reg[a];
            end
        end
    end

    // P6: start plus scaled delta, saturate, output register
    logic [64:0]        p_c   [3];
    logic signed [66:0] sum_c [3];
    logic signed [31:0] pt_c  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            p_c[a]   = prod5_reg[a] >> FRAC_BITS;
            sum_c[a] = 67'(s5_reg[a])
                     + (neg5_reg[a] ? -$signed({2'b00, p_c[a]}) : $signed({2'b00, p_c[a]}));
            if (sum_c[a] > 67'(rbsi_pkg::T_MAX)) begin
                pt_c[a] = rbsi_pkg::T_MAX;
            end else if (sum_c[a] < 67'(rbsi_pkg::T_MIN)) begin
                pt_c[a] = rbsi_pkg::T_MIN;
            end else begin
                pt_c[a] = sum_c[a][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= v5_reg;
        end
        if (en) begin
            m_hit     <= hit5_reg;
            m_t_entry <= hit5_reg ? tm5_reg : '0;
            m_face    <= hit5_reg ? face5_reg : rbsi_pkg::FACE_X_LO;
            m_point_x <= hit5_reg ? pt_c[0] : '0;
            m_point_y <= hit5_reg ? pt_c[1] : '0;
            m_point_z <= hit5_reg ? pt_c[2] : '0;
        end
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_t_entry == 0 && m_face == rbsi_pkg::FACE_X_LO
            && m_point_x == 0 && m_point_y == 0 && m_point_z == 0)
        else $error("miss result carries non-zero fields");
    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_face <= rbsi_pkg::FACE_Z_HI)
        else $error("face code out of range");
    a_entry_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_t_entry != rbsi_pkg::T_MAX)
        else $error("hit with entry at upper t limit");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && m_valid && !m_ready |=> v5_reg && m_valid)
        else $error("stall dropped an item in flight");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the ray/box slab intersection unit.
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC        = 16;
    localparam int MAXLVL      = 14;
    localparam int N_RANDOM    = 1200;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct packed {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic signed [15:0] bx, by, bz;
        logic        [3:0]  lvl;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t;
        logic        [2:0]  face;
        logic signed [31:0] px, py, pz;
    } isect_t;

    typedef struct {
        ray_t   r;
        logic   known;
        isect_t res;
    } row_t;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [31:0] s_start_x, s_start_y, s_start_z, s_end_x, s_end_y, s_end_z;
    logic signed [15:0] s_box_x, s_box_y, s_box_z;
    logic [3:0] s_box_level;
    logic m_hit;
    logic signed [31:0] m_t_entry, m_point_x, m_point_y, m_point_z;
    logic [2:0] m_face;

    ray_box_slab_intersect_unit dut (.*);

    isect_t pending_hits[$];
    int     errors = 0;
    int     n_sent = 0, n_recv = 0, n_hits = 0;
    int     idle_cnt = 0;
    bit     calm = 0;
    bit     hold_off = 0;
    bit     done_sending = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
        if (v > 66'sh7fffffff) return rbsi_pkg::T_MAX;
        if (v < -66'sh80000000) return rbsi_pkg::T_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] slab_div(input logic signed [65:0] num,
                                                    input logic signed [65:0] den);
        logic        neg;
        logic [65:0] un, ud, q, r, mag;
        neg = (num < 0) != (den < 0);
        un  = num < 0 ? -num : num;
        ud  = den < 0 ? -den : den;
        q   = un / ud;
        r   = un % ud;
        if (q >= (66'd1 << (32 - FRAC))) mag = 66'd1 << 32;
        else mag = (q << FRAC) + ((r << FRAC) / ud);
        if (un == 0) neg = 0;
        return clip32(neg ? -$signed(mag) : $signed(mag));
    endfunction

    function automatic logic signed [31:0] hit_coord(input logic signed [65:0] s,
                                                     input logic signed [65:0] d,
                                                     input logic signed [31:0] t);
        logic         neg;
        logic [65:0]  p, mt, md;
        neg = (t < 0) != (d < 0);
        mt  = t < 0 ? -66'(t) : 66'(t);
        md  = d < 0 ? -d : d;
        p   = (mt * md) >> FRAC;
        return clip32(s + (neg ? -$signed(p) : $signed(p)));
    endfunction

    function automatic isect_t slab_intersect(input ray_t r);
        isect_t res;
        logic signed [65:0] s[3], d[3], lo[3], hi[3];
        logic signed [31:0] tlo[3], thi[3], tin[3], tout[3], tmax, tmin;
        logic signed [15:0] b[3];
        int lvl;
        res = '0;
        lvl = r.lvl > MAXLVL ? MAXLVL : r.lvl;
        s[0] = r.sx; s[1] = r.sy; s[2] = r.sz;
        d[0] = 66'(r.ex) - r.sx; d[1] = 66'(r.ey) - r.sy; d[2] = 66'(r.ez) - r.sz;
        b[0] = r.bx; b[1] = r.by; b[2] = r.bz;
        for (int a = 0; a < 3; a++) begin
            lo[a] = 66'(b[a]) <<< FRAC;
            hi[a] = (66'(b[a]) + (66'sd1 <<< lvl)) <<< FRAC;
            if (d[a] == 0) begin
                if (s[a] < lo[a] || s[a] > hi[a]) return res;
                tlo[a] = rbsi_pkg::T_MIN;
                thi[a] = rbsi_pkg::T_MAX;
            end else begin
                tlo[a] = slab_div(lo[a] - s[a], d[a]);
                thi[a] = slab_div(hi[a] - s[a], d[a]);
            end
            if (tlo[a] < thi[a]) begin
                tin[a] = tlo[a]; tout[a] = thi[a];
            end else begin
                tin[a] = thi[a]; tout[a] = tlo[a];
            end
        end
        tmax = tin[0];
        tmin = tout[0];
        for (int a = 1; a < 3; a++) begin
            if (tin[a] > tmax) tmax = tin[a];
            if (tout[a] < tmin) tmin = tout[a];
        end
        if (!(tmax < tmin)) return res;
        res.hit = 1;
        res.t = tmax;
        if (tmax == tin[0])
            res.face = tmax == tlo[0] ? rbsi_pkg::FACE_X_LO : rbsi_pkg::FACE_X_HI;
        else if (tmax == tin[1])
            res.face = tmax == tlo[1] ? rbsi_pkg::FACE_Y_LO : rbsi_pkg::FACE_Y_HI;
        else
            res.face = tmax == tlo[2] ? rbsi_pkg::FACE_Z_LO : rbsi_pkg::FACE_Z_HI;
        res.px = hit_coord(s[0], d[0], tmax);
        res.py = hit_coord(s[1], d[1], tmax);
        res.pz = hit_coord(s[2], d[2], tmax);
        return res;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int   mode;
        r    = '0;
        mode = $urandom_range(0, 9);
        r.lvl = 4'($urandom_range(0, 15));
        if (mode < 6) begin
            // rays aimed through or near a cube placed near the origin
            r.bx = 16'($urandom_range(0, 64) - 32);
            r.by = 16'($urandom_range(0, 64) - 32);
            r.bz = 16'($urandom_range(0, 64) - 32);
            if (mode < 4) r.lvl = 4'($urandom_range(0, 5));
            r.sx = (32'(r.bx) <<< FRAC) + $urandom_range(0, 8 << FRAC) - (4 << FRAC)
                   - ($urandom_range(0, 64) << FRAC);
            r.sy = (32'(r.by) <<< FRAC) + $urandom_range(0, 8 << FRAC) - (4 << FRAC)
                   - ($urandom_range(0, 64) << FRAC);
            r.sz = (32'(r.bz) <<< FRAC) + $urandom_range(0, 8 << FRAC) - (4 << FRAC)
                   - ($urandom_range(0, 64) << FRAC);
            r.ex = (32'(r.bx) <<< FRAC) + $urandom_range(0, 80 << FRAC);
            r.ey = (32'(r.by) <<< FRAC) + $urandom_range(0, 80 << FRAC);
            r.ez = (32'(r.bz) <<< FRAC) + $urandom_range(0, 80 << FRAC);
            if ($urandom_range(0, 3) == 0) r.ex = r.sx;
            if ($urandom_range(0, 3) == 0) r.ey = r.sy;
            if ($urandom_range(0, 7) == 0) r.sz = 32'(r.bz) <<< FRAC;
            if ($urandom_range(0, 1)) begin
                {r.sx, r.ex} = {r.ex, r.sx};
            end
        end else begin
            r.sx = $urandom; r.sy = $urandom; r.sz = $urandom;
            r.ex = $urandom; r.ey = $urandom; r.ez = $urandom;
            r.bx = 16'($urandom); r.by = 16'($urandom); r.bz = 16'($urandom);
            if (mode == 9) begin
                r.sx = r.sx >>> 12; r.sy = r.sy >>> 12; r.sz = r.sz >>> 12;
                r.ex = r.ex >>> 12; r.ey = r.ey >>> 12; r.ez = r.ez >>> 12;
                r.bx = r.bx >>> 12; r.by = r.by >>> 12; r.bz = r.bz >>> 12;
            end
        end
        return r;
    endfunction

    task automatic send_ray(input ray_t r);
        while (!calm && $urandom_range(0, 99) < 29) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid     <= 1;
        s_start_x   <= r.sx; s_start_y <= r.sy; s_start_z <= r.sz;
        s_end_x     <= r.ex; s_end_y   <= r.ey; s_end_z   <= r.ez;
        s_box_x     <= r.bx; s_box_y   <= r.by; s_box_z   <= r.bz;
        s_box_level <= r.lvl;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic queue_and_send(input ray_t r);
        pending_hits.push_back(slab_intersect(r));
        send_ray(r);
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps going
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else if (hold_off) begin
            m_ready <= 0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge aclk) begin
        isect_t want;
        if (aresetn && m_valid && m_ready) begin
            n_recv++;
            if (m_hit) n_hits++;
            if (pending_hits.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, m_hit); errors++;
                end
                if (m_t_entry !== want.t) begin
                    $error("t_entry: expected %0h actual %0h", want.t, m_t_entry); errors++;
                end
                if (m_face !== want.face) begin
                    $error("face: expected %0d actual %0d", want.face, m_face); errors++;
                end
                if (m_point_x !== want.px) begin
                    $error("point_x: expected %0h actual %0h", want.px, m_point_x); errors++;
                end
                if (m_point_y !== want.py) begin
                    $error("point_y: expected %0h actual %0h", want.py, m_point_y); errors++;
                end
                if (m_point_z !== want.pz) begin
                    $error("point_z: expected %0h actual %0h", want.pz, m_point_z); errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cnt <= 0;
        end else if (s_valid || pending_hits.size() != 0) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        row_t rows[$];
        row_t rw;
        isect_t miss;
        int i;
        miss = '0;
        aresetn = 0; s_valid = 0;
        s_start_x = 0; s_start_y = 0; s_start_z = 0;
        s_end_x = 0; s_end_y = 0; s_end_z = 0;
        s_box_x = 0; s_box_y = 0; s_box_z = 0; s_box_level = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed rows: {sx,sy,sz,ex,ey,ez,bx,by,bz,lvl}, known flag, expected
        rw.known = 0; rw.res = '0;
        rw.r = {32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'sd5, 16'sd0, 16'sd0, 4'd0};
        rw.known = 1; rw.res = miss; rows.push_back(rw);           // degenerate, outside x
        rw.r = {32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rw.known = 0; rows.push_back(rw);                          // zero delta inside
        rw.r = {-32'sh20000, 32'sh8000, 32'sh8000, 32'sh20000, 32'sh8000, 32'sh8000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);                                        // x low face
        rw.r = {32'sh20000, 32'sh8000, 32'sh8000, -32'sh20000, 32'sh8000, 32'sh8000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);                                        // x high face
        rw.r = {32'sh8000, -32'sh20000, 32'sh8000, 32'sh8000, 32'sh20000, 32'sh8000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);
        rw.r = {32'sh8000, 32'sh20000, 32'sh8000, 32'sh8000, -32'sh20000, 32'sh8000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);
        rw.r = {32'sh8000, 32'sh8000, -32'sh20000, 32'sh8000, 32'sh8000, 32'sh20000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);
        rw.r = {32'sh8000, 32'sh8000, 32'sh20000, 32'sh8000, 32'sh8000, -32'sh20000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);
        rw.r = {-32'sh10000, -32'sh10000, -32'sh10000, 32'sh30000, 32'sh30000, 32'sh30000,
                16'sd0, 16'sd0, 16'sd0, 4'd1};
        rows.push_back(rw);                                        // corner tie, x wins
        rw.r = {32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);                                        // start on the planes
        rw.r = {32'sh10000, 32'sh8000, 32'sh8000, 32'sh10000, 32'sh8000, 32'sh8000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);                                        // on high plane, zero delta
        rw.r = {32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 4'd15};
        rows.push_back(rw);                                        // extremes, level clamp
        rw.r = {32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                32'sh7fffffff, 16'sh8000, 16'sh8000, 16'sh8000, 4'd14};
        rows.push_back(rw);
        rw.r = {32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh1, 32'sh1, 16'sd0, 16'sd0, 16'sd0, 4'd14};
        rows.push_back(rw);                                        // tiny delta, t saturates
        rw.r = {32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 16'sd100, 16'sd0, 16'sd0, 4'd0};
        rows.push_back(rw);
        rw.r = {32'sh10000, 32'sh8000, 32'sh8000, 32'sh10000, 32'sh8000, 32'sh8000,
                16'sd2, 16'sd0, 16'sd0, 4'd3};
        rw.known = 1; rw.res = miss; rows.push_back(rw);           // zero delta below low
        rw.r = {32'sh50000, 32'sh50000, 32'sh50000, 32'sh60000, 32'sh60000, 32'sh60000,
                16'sd0, 16'sd0, 16'sd0, 4'd0};
        rw.known = 0; rows.push_back(rw);                          // box behind the start
        rw.r = {-32'sh30000, 32'sh30000, 32'sh8000, 32'sh30000, -32'sh30000, 32'sh8000,
                16'sd5, 16'sd5, 16'sd0, 4'd0};
        rows.push_back(rw);

        foreach (rows[k]) begin
            if (rows[k].known) pending_hits.push_back(rows[k].res);
            else pending_hits.push_back(slab_intersect(rows[k].r));
            send_ray(rows[k].r);
        end

        for (i = 0; i < N_RANDOM; i++) begin
            calm = (i >= 400 && i < 550);
            if (i == 700) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (150) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            queue_and_send(random_ray());
        end
        calm = 0;
        s_valid <= 0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Sent %0d rays, checked %0d results (%0d hits) incl. zero-delta, saturation",
                 n_sent, n_recv, n_hits);
        $display("and face-tie rows, with random stalls and a long receiver hold-off.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
